// ===== design/cosine_similarity_engine_core_defines.svh =====
// Assertion macros used by the cosine similarity engine controller.
`ifndef COSINE_SIMILARITY_ENGINE_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication on the block clock, off during reset.
`define CSE_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cse check failed");

// Next-cycle implication on the block clock, off during reset.
`define CSE_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cse check failed");

`endif

// ===== design/cse_pkg.sv =====
// Types and constants shared by the cosine similarity engine modules.
`timescale 1ns / 1ps

package cse_pkg;

   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int SQ_PROD_W  = PROD_W - 1;
   localparam int ACC_W      = 42;
   localparam int NORM_W     = 30;
   localparam int NORM_SHIFT = 20;
   localparam int RAD_W      = ACC_W + NORM_SHIFT;
   localparam int SQ_W       = RAD_W + 1;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int D_W        = 2 * ROOT_W;
   localparam int Q_W        = 16;
   localparam int SIM_W      = 16;
   localparam int CNT_W      = 5;

   localparam int SQRT_STEPS = SQ_W / 2 + 1;
   localparam int DIV_STEPS  = Q_W;

   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

   localparam logic [NORM_W-1:0] MIN_NORM_RESET = NORM_W'(11);

   localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << (SQ_W - 1 - (SQ_W % 2 == 0 ? 1 : 0)
                                                       - ((SQ_W - 1) % 2));

   localparam logic signed [ACC_W-1:0] DOT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DOT_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [ACC_W-1:0]        NORM_MAX = {ACC_W{1'b1}};

   localparam logic [SIM_W-1:0] SIM_POS_MAX = {1'b0, {(SIM_W-1){1'b1}}};
   localparam logic [SIM_W-1:0] SIM_ONE     = {1'b1, {(SIM_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_ACC,
      ST_FLUSH,
      ST_CHECK,
      ST_SQRT_A,
      ST_LOAD_B,
      ST_SQRT_B,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic accumulate;
      logic check;
      logic sqrt_load_a;
      logic sqrt_load_b;
      logic sqrt_step;
      logic save_ra;
      logic mul;
      logic div_load;
      logic div_step;
      logic load_rsp;
      logic clear_acc;
   } cmd_type;

   typedef struct packed {
      logic below_floor;
      logic rsp_busy;
   } status_type;

endpackage

// ===== design/cosine_similarity_engine_core.sv =====
// Top level of the cosine similarity engine: controller and datapath.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_elem_a, req_elem_b, req_last
//  rsp      out  rsp_valid/rsp_ready    rsp_similarity, rsp_degenerate
//  csr      in   csr_wr_en              csr_wr_data (min_norm)
//
// Items without last are taken one per cycle through a registered multiply stage.
// An item with last holds the input until its result is loaded; if no norm is under the floor,
// one square-root unit runs 32 steps per norm, then one 31x31 multiply and 16 divide steps.
// The result waits in an output register; a later last item waits only if it is still held.
// Reset is synchronous, active high; it clears the accumulators and sets min_norm to 11.
`timescale 1ns / 1ps

module cosine_similarity_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cse_pkg::ELEM_W-1:0]   req_elem_a,
   input  logic signed [cse_pkg::ELEM_W-1:0]   req_elem_b,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cse_pkg::SIM_W-1:0]    rsp_similarity,
   output logic                                rsp_degenerate,
   input  logic                                csr_wr_en,
   input  logic [cse_pkg::NORM_W-1:0]          csr_wr_data
);

   cse_pkg::cmd_type     cmd;
   cse_pkg::status_type  status;

   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .status    (status),
      .cmd       (cmd)
   );

   cse_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_elem_a     (req_elem_a),
      .req_elem_b     (req_elem_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_similarity (rsp_similarity),
      .rsp_degenerate (rsp_degenerate),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

endmodule

// ===== design/cse_datapath.sv =====
// Datapath: products, saturating accumulators, shared square root, divider, result register.
`timescale 1ns / 1ps

module cse_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cse_pkg::cmd_type                    cmd,
   output cse_pkg::status_type                 status,
   input  logic signed [cse_pkg::ELEM_W-1:0]   req_elem_a,
   input  logic signed [cse_pkg::ELEM_W-1:0]   req_elem_b,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cse_pkg::SIM_W-1:0]    rsp_similarity,
   output logic                                rsp_degenerate,
   input  logic                                csr_wr_en,
   input  logic [cse_pkg::NORM_W-1:0]          csr_wr_data
);

   logic signed [cse_pkg::PROD_W-1:0]    prod_ab_ff, prod_ab_in;
   logic [cse_pkg::SQ_PROD_W-1:0]        prod_aa_ff, prod_aa_in;
   logic [cse_pkg::SQ_PROD_W-1:0]        prod_bb_ff, prod_bb_in;
   logic signed [cse_pkg::PROD_W-1:0]    sq_a_full, sq_b_full;

   logic signed [cse_pkg::ACC_W-1:0]     dot_acc_ff, dot_acc_in;
   logic [cse_pkg::ACC_W-1:0]            norm_a_acc_ff, norm_a_acc_in;
   logic [cse_pkg::ACC_W-1:0]            norm_b_acc_ff, norm_b_acc_in;
   logic signed [cse_pkg::ACC_W:0]       dot_sum;
   logic [cse_pkg::ACC_W:0]              norm_a_sum, norm_b_sum;

   logic [cse_pkg::NORM_W-1:0]           min_norm_ff, min_norm_in;

   logic [cse_pkg::SQ_W-1:0]             sq_n_ff, sq_n_in;
   logic [cse_pkg::SQ_W-1:0]             sq_res_ff, sq_res_in;
   logic [cse_pkg::SQ_W-1:0]             sq_bit_ff, sq_bit_in;
   logic [cse_pkg::SQ_W-1:0]             sq_trial;
   logic [cse_pkg::ROOT_W-1:0]           ra_ff, ra_in;

   logic [cse_pkg::D_W-1:0]              d_ff, d_in;
   logic [cse_pkg::D_W-1:0]              d_mul;

   logic [cse_pkg::ACC_W-1:0]            dot_mag;
   logic [cse_pkg::SQ_W-1:0]             rem_init, rem_shift, d_ext;
   logic                                 rem_ge;
   logic [cse_pkg::SQ_W-1:0]             rem_ff, rem_in;
   logic [cse_pkg::Q_W-1:0]              q_ff, q_in;
   logic                                 ovf_ff, ovf_in;
   logic                                 degen_ff, degen_in;

   logic [cse_pkg::Q_W:0]                q_round;
   logic [cse_pkg::SIM_W-1:0]            mag;
   logic [cse_pkg::SIM_W-1:0]            sim_val;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [cse_pkg::SIM_W-1:0]            rsp_sim_ff, rsp_sim_in;
   logic                                 rsp_deg_ff, rsp_deg_in;

   // products
   assign sq_a_full  = req_elem_a * req_elem_a;
   assign sq_b_full  = req_elem_b * req_elem_b;
   assign prod_ab_in = cmd.capture ? req_elem_a * req_elem_b : prod_ab_ff;
   assign prod_aa_in = cmd.capture ? sq_a_full[cse_pkg::SQ_PROD_W-1:0] : prod_aa_ff;
   assign prod_bb_in = cmd.capture ? sq_b_full[cse_pkg::SQ_PROD_W-1:0] : prod_bb_ff;

   // saturating accumulate
   assign dot_sum    = (cse_pkg::ACC_W+1)'(dot_acc_ff) + (cse_pkg::ACC_W+1)'(prod_ab_ff);
   assign norm_a_sum = {1'b0, norm_a_acc_ff} + (cse_pkg::ACC_W+1)'(prod_aa_ff);
   assign norm_b_sum = {1'b0, norm_b_acc_ff} + (cse_pkg::ACC_W+1)'(prod_bb_ff);

   always_comb begin
      dot_acc_in    = dot_acc_ff;
      norm_a_acc_in = norm_a_acc_ff;
      norm_b_acc_in = norm_b_acc_ff;
      if (cmd.clear_acc) begin
         dot_acc_in    = '0;
         norm_a_acc_in = '0;
         norm_b_acc_in = '0;
      end else if (cmd.accumulate) begin
         if (dot_sum[cse_pkg::ACC_W] != dot_sum[cse_pkg::ACC_W-1]) begin
            dot_acc_in = dot_sum[cse_pkg::ACC_W] ? cse_pkg::DOT_MIN : cse_pkg::DOT_MAX;
         end else begin
            dot_acc_in = dot_sum[cse_pkg::ACC_W-1:0];
         end
         norm_a_acc_in = norm_a_sum[cse_pkg::ACC_W] ? cse_pkg::NORM_MAX
                                                    : norm_a_sum[cse_pkg::ACC_W-1:0];
         norm_b_acc_in = norm_b_sum[cse_pkg::ACC_W] ? cse_pkg::NORM_MAX
                                                    : norm_b_sum[cse_pkg::ACC_W-1:0];
      end
   end

   assign min_norm_in = csr_wr_en ? csr_wr_data : min_norm_ff;

   assign status.below_floor = (norm_a_acc_ff < cse_pkg::ACC_W'(min_norm_ff)) ||
                               (norm_b_acc_ff < cse_pkg::ACC_W'(min_norm_ff));

   // shared square root, one bit pair per cycle
   assign sq_trial = sq_res_ff + sq_bit_ff;

   always_comb begin
      sq_n_in   = sq_n_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      if (cmd.sqrt_load_a || cmd.sqrt_load_b) begin
         sq_n_in   = cmd.sqrt_load_a ? cse_pkg::SQ_W'({norm_a_acc_ff, cse_pkg::NORM_SHIFT'(0)})
                                     : cse_pkg::SQ_W'({norm_b_acc_ff, cse_pkg::NORM_SHIFT'(0)});
         sq_res_in = '0;
         sq_bit_in = cse_pkg::SQ_BIT_INIT;
      end else if (cmd.sqrt_step) begin
         if (sq_n_ff >= sq_trial) begin
            sq_n_in   = sq_n_ff - sq_trial;
            sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_in = sq_res_ff >> 1;
         end
         sq_bit_in = sq_bit_ff >> 2;
      end
   end

   assign ra_in = cmd.save_ra ? sq_res_ff[cse_pkg::ROOT_W-1:0] : ra_ff;

   assign d_mul = ra_ff * sq_res_ff[cse_pkg::ROOT_W-1:0];
   assign d_in  = cmd.mul ? d_mul : d_ff;

   // restoring divide, one quotient bit per cycle
   assign dot_mag   = dot_acc_ff[cse_pkg::ACC_W-1] ? cse_pkg::ACC_W'(-dot_acc_ff)
                                                   : cse_pkg::ACC_W'(dot_acc_ff);
   assign rem_init  = cse_pkg::SQ_W'({dot_mag, cse_pkg::NORM_SHIFT'(0)});
   assign d_ext     = cse_pkg::SQ_W'(d_ff);
   assign rem_shift = {rem_ff[cse_pkg::SQ_W-2:0], 1'b0};
   assign rem_ge    = rem_shift >= d_ext;

   always_comb begin
      rem_in   = rem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      degen_in = degen_ff;
      if (cmd.check) begin
         degen_in = status.below_floor;
      end
      if (cmd.div_load) begin
         rem_in   = rem_init;
         q_in     = '0;
         ovf_in   = rem_init >= d_ext;
         degen_in = (d_ff == '0);
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? rem_shift - d_ext : rem_shift;
         q_in   = {q_ff[cse_pkg::Q_W-2:0], rem_ge};
      end
   end

   // round half up, sign and clamp
   assign q_round = {1'b0, q_ff} + (cse_pkg::Q_W+1)'(1);
   assign mag     = ovf_ff ? cse_pkg::SIM_ONE : q_round[cse_pkg::Q_W:1];

   always_comb begin
      if (degen_ff) begin
         sim_val = '0;
      end else if (dot_acc_ff[cse_pkg::ACC_W-1]) begin
         sim_val = cse_pkg::SIM_W'(-mag);
      end else if (mag[cse_pkg::SIM_W-1]) begin
         sim_val = cse_pkg::SIM_POS_MAX;
      end else begin
         sim_val = mag;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sim_in   = rsp_sim_ff;
      rsp_deg_in   = rsp_deg_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_sim_in   = sim_val;
         rsp_deg_in   = degen_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_degenerate = rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_acc_ff    <= '0;
         norm_a_acc_ff <= '0;
         norm_b_acc_ff <= '0;
         min_norm_ff   <= cse_pkg::MIN_NORM_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dot_acc_ff    <= dot_acc_in;
         norm_a_acc_ff <= norm_a_acc_in;
         norm_b_acc_ff <= norm_b_acc_in;
         min_norm_ff   <= min_norm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ab_ff <= prod_ab_in;
      prod_aa_ff <= prod_aa_in;
      prod_bb_ff <= prod_bb_in;
      sq_n_ff    <= sq_n_in;
      sq_res_ff  <= sq_res_in;
      sq_bit_ff  <= sq_bit_in;
      ra_ff      <= ra_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      ovf_ff     <= ovf_in;
      degen_ff   <= degen_in;
      rsp_sim_ff <= rsp_sim_in;
      rsp_deg_ff <= rsp_deg_in;
   end

endmodule

// ===== design/cse_ctrl.sv =====
// Controller: sequences accumulate, square roots, multiply, divide and result hand-off.
`timescale 1ns / 1ps
`include "cosine_similarity_engine_core_defines.svh"

module cse_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_last,
   input  cse_pkg::status_type   status,
   output cse_pkg::cmd_type      cmd
);

   cse_pkg::state_type           state_ff, state_in;
   logic [cse_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         pend_ff, pend_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cse_pkg::ST_ACC: begin
            if (req_valid && req_last) begin
               state_in = cse_pkg::ST_FLUSH;
            end
         end
         cse_pkg::ST_FLUSH: begin
            state_in = cse_pkg::ST_CHECK;
         end
         cse_pkg::ST_CHECK: begin
            state_in = status.below_floor ? cse_pkg::ST_DONE : cse_pkg::ST_SQRT_A;
         end
         cse_pkg::ST_SQRT_A: begin
            if (cnt_ff == cse_pkg::SQRT_LAST) begin
               state_in = cse_pkg::ST_LOAD_B;
            end
         end
         cse_pkg::ST_LOAD_B: begin
            state_in = cse_pkg::ST_SQRT_B;
         end
         cse_pkg::ST_SQRT_B: begin
            if (cnt_ff == cse_pkg::SQRT_LAST) begin
               state_in = cse_pkg::ST_MUL;
            end
         end
         cse_pkg::ST_MUL: begin
            state_in = cse_pkg::ST_DIV_INIT;
         end
         cse_pkg::ST_DIV_INIT: begin
            state_in = cse_pkg::ST_DIV;
         end
         cse_pkg::ST_DIV: begin
            if (cnt_ff == cse_pkg::DIV_LAST) begin
               state_in = cse_pkg::ST_DONE;
            end
         end
         cse_pkg::ST_DONE: begin
            if (!status.rsp_busy) begin
               state_in = cse_pkg::ST_ACC;
            end
         end
         default: begin
            state_in = cse_pkg::ST_ACC;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      cmd.accumulate = pend_ff;
      case (state_ff)
         cse_pkg::ST_ACC: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         cse_pkg::ST_CHECK: begin
            cmd.check       = 1'b1;
            cmd.sqrt_load_a = !status.below_floor;
         end
         cse_pkg::ST_SQRT_A: begin
            cmd.sqrt_step = 1'b1;
         end
         cse_pkg::ST_LOAD_B: begin
            cmd.save_ra     = 1'b1;
            cmd.sqrt_load_b = 1'b1;
         end
         cse_pkg::ST_SQRT_B: begin
            cmd.sqrt_step = 1'b1;
         end
         cse_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         cse_pkg::ST_DIV_INIT: begin
            cmd.div_load = 1'b1;
         end
         cse_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         cse_pkg::ST_DONE: begin
            cmd.load_rsp  = !status.rsp_busy;
            cmd.clear_acc = !status.rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.sqrt_load_a || cmd.sqrt_load_b || cmd.div_load) begin
         cnt_in = '0;
      end else if (cmd.sqrt_step || cmd.div_step) begin
         cnt_in = cnt_ff + cse_pkg::CNT_W'(1);
      end
   end

   assign pend_in = cmd.capture;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cse_pkg::ST_ACC;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   `CSE_CHECK_NEXT(a_last_blocks_input, cmd.capture && req_last, !req_ready)
   `CSE_CHECK_NOW(a_load_when_free, cmd.load_rsp, !status.rsp_busy)
   `CSE_CHECK_NEXT(a_clear_no_accumulate, cmd.clear_acc, !cmd.accumulate)
   `CSE_CHECK_NEXT(a_sqrt_start, cmd.sqrt_load_a, (state_ff == cse_pkg::ST_SQRT_A) && (cnt_ff == '0))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the cosine similarity engine core.
`timescale 1ns / 1ps

module testbench;

   localparam longint DOT_HI    = 64'h1FF_FFFF_FFFF;
   localparam longint DOT_LO    = -DOT_HI - 1;
   localparam longint ENERGY_HI = 64'h3FF_FFFF_FFFF;
   localparam int     LIMIT     = 1000000;
   localparam int     SETTLE    = 100;

   typedef struct {
      logic signed [cse_pkg::ELEM_W-1:0] elem_a;
      logic signed [cse_pkg::ELEM_W-1:0] elem_b;
      logic                              last;
      int                                gap;
   } pair_type;

   typedef struct {
      logic signed [cse_pkg::SIM_W-1:0] similarity;
      logic                             degenerate;
   } score_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [cse_pkg::ELEM_W-1:0]  req_elem_a = '0;
   logic signed [cse_pkg::ELEM_W-1:0]  req_elem_b = '0;
   logic                               req_last = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [cse_pkg::SIM_W-1:0]   rsp_similarity;
   logic                               rsp_degenerate;
   logic                               csr_wr_en = 1'b0;
   logic [cse_pkg::NORM_W-1:0]         csr_wr_data = '0;

   pair_type  pair_q[$];
   score_type score_q[$];
   pair_type  cur_pair;
   score_type want;

   logic signed [41:0]          dot_sum = '0;
   logic [41:0]                 energy_a = '0;
   logic [41:0]                 energy_b = '0;
   logic [cse_pkg::NORM_W-1:0]  floor_cfg = cse_pkg::NORM_W'(11);

   int pushed_cnt = 0;
   int accepted_cnt = 0;
   int gap_cnt = 0;
   int results_seen = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int mismatch_cnt = 0;
   int cycle_cnt = 0;

   cosine_similarity_engine_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_elem_a     (req_elem_a),
      .req_elem_b     (req_elem_b),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_similarity (rsp_similarity),
      .rsp_degenerate (rsp_degenerate),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      int          i;
      r = '0;
      for (i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic score_type cosine_score();
      score_type   s;
      logic [63:0] ra;
      logic [63:0] rb;
      logic [63:0] d;
      logic [63:0] mag;
      logic [99:0] quo;
      logic [16:0] m;
      logic [15:0] r;
      logic        neg;
      s.similarity = '0;
      s.degenerate = 1'b0;
      if (energy_a < floor_cfg || energy_b < floor_cfg) begin
         s.degenerate = 1'b1;
         return s;
      end
      ra = root_floor({2'b00, energy_a, 20'd0});
      rb = root_floor({2'b00, energy_b, 20'd0});
      d  = ra * rb;
      if (d == 0) begin
         s.degenerate = 1'b1;
         return s;
      end
      neg = dot_sum < 0;
      mag = neg ? 64'(-longint'(dot_sum)) : 64'(longint'(dot_sum));
      if ((mag << 20) >= d) begin
         m = 17'd32768;
      end else begin
         quo = {mag, 36'd0} / {36'd0, d};
         m = (quo[16:0] + 17'd1) >> 1;
      end
      r = m[15:0];
      if (neg) s.similarity = 16'd0 - r;
      else if (m > 17'd32767) s.similarity = 16'h7FFF;
      else s.similarity = r;
      return s;
   endfunction

   function automatic void fold_pair(input pair_type p);
      longint sum;
      longint ea;
      longint eb;
      sum = longint'(dot_sum) + longint'(p.elem_a) * longint'(p.elem_b);
      if (sum > DOT_HI) sum = DOT_HI;
      else if (sum < DOT_LO) sum = DOT_LO;
      dot_sum = sum[41:0];
      ea = longint'(energy_a) + longint'(p.elem_a) * longint'(p.elem_a);
      eb = longint'(energy_b) + longint'(p.elem_b) * longint'(p.elem_b);
      if (ea > ENERGY_HI) ea = ENERGY_HI;
      if (eb > ENERGY_HI) eb = ENERGY_HI;
      energy_a = ea[41:0];
      energy_b = eb[41:0];
      if (p.last) begin
         score_q.push_back(cosine_score());
         dot_sum  = '0;
         energy_a = '0;
         energy_b = '0;
      end
   endfunction

   // Driver: present queued items after each one's gap, hold until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (req_valid && req_ready) begin
            fold_pair(cur_pair);
            accepted_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (pair_q.size() != 0 && gap_cnt >= pair_q[0].gap) begin
               cur_pair = pair_q.pop_front();
               gap_cnt = 0;
               req_valid  <= 1'b1;
               req_elem_a <= cur_pair.elem_a;
               req_elem_b <= cur_pair.elem_b;
               req_last   <= cur_pair.last;
            end else begin
               if (pair_q.size() != 0) gap_cnt++;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result, then stall ready for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (score_q.size() == 0) begin
               $display("%0t unexpected result: expected none actual similarity %0d degenerate %0b",
                        $time, rsp_similarity, rsp_degenerate);
               mismatch_cnt++;
            end else begin
               want = score_q.pop_front();
               if (want.similarity !== rsp_similarity) begin
                  $display("%0t similarity mismatch: expected %0d actual %0d",
                           $time, want.similarity, rsp_similarity);
                  mismatch_cnt++;
               end
               if (want.degenerate !== rsp_degenerate) begin
                  $display("%0t degenerate mismatch: expected %0b actual %0b",
                           $time, want.degenerate, rsp_degenerate);
                  mismatch_cnt++;
               end
            end
            results_seen++;
            stall_left = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
         end
         if (!long_hold_done && results_seen >= 30 && pair_q.size() > 100) begin
            hold_left = 600;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT) begin
         $display("cosine_similarity_engine_core verification failed");
         $finish;
      end
   end

   task automatic push_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                            input int gap);
      pair_type p;
      p.elem_a = a;
      p.elem_b = b;
      p.last   = last;
      p.gap    = gap;
      pair_q.push_back(p);
      pushed_cnt++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_cnt != pushed_cnt || score_q.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_floor(input logic [cse_pkg::NORM_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      floor_cfg = v;
      @(negedge clock);
   endtask

   function automatic logic [15:0] draw_elem();
      case ($urandom_range(0, 9))
         0, 1: return 16'(int'($urandom_range(0, 127)) - 64);
         2: begin
            case ($urandom_range(0, 5))
               0: return 16'h8000;
               1: return 16'h8001;
               2: return 16'hFFFF;
               3: return 16'h0000;
               4: return 16'h0001;
               default: return 16'h7FFF;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int n_items);
      int          sent;
      int          len;
      int          k;
      int          flavor;
      bit          quiet;
      logic [15:0] a;
      logic [15:0] b;
      sent = 0;
      while (sent < n_items) begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         flavor = $urandom_range(0, 6);
         quiet  = ($urandom_range(0, 4) == 0);
         for (k = 0; k < len; k++) begin
            a = draw_elem();
            case (flavor)
               0: b = a;
               1: b = 16'd0 - a;
               2: b = a + 16'(int'($urandom_range(0, 63)) - 32);
               3: begin
                  a = 16'(int'($urandom_range(0, 7)) - 4);
                  b = 16'(int'($urandom_range(0, 7)) - 4);
               end
               default: b = draw_elem();
            endcase
            push_pair(a, b, k == len - 1, quiet ? 0 : $urandom_range(0, 19));
         end
         sent += len;
      end
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_pair(16'h0000, 16'h0000, 1'b1, 0);
      push_pair(16'h7FFF, 16'h7FFF, 1'b1, 3);
      push_pair(16'h8000, 16'h8000, 1'b1, 0);
      push_pair(16'h8000, 16'h7FFF, 1'b1, 5);
      push_pair(16'h7FFF, 16'h8000, 1'b1, 0);
      push_pair(16'h7FFF, 16'h0000, 1'b0, 0);
      push_pair(16'h0000, 16'h7FFF, 1'b1, 2);
      push_pair(16'h0001, 16'h0000, 1'b0, 0);
      push_pair(16'h0000, 16'h0001, 1'b1, 0);
      push_pair(16'h5555, 16'hAAAA, 1'b0, 1);
      push_pair(16'hAAAA, 16'h5555, 1'b1, 0);
      push_pair(16'd3, 16'd4, 1'b1, 0);
      push_pair(16'(100), 16'(-50), 1'b0, 0);
      push_pair(16'(-200), 16'(25), 1'b0, 7);
      push_pair(16'(300), 16'(400), 1'b1, 0);
      wait_idle();

      set_floor('0);
      push_pair(16'h0000, 16'h0000, 1'b1, 0);
      push_pair(16'h0000, 16'd5, 1'b0, 0);
      push_pair(16'h0000, 16'(-7), 1'b1, 4);
      push_pair(16'h0001, 16'h0001, 1'b1, 0);
      push_pair(16'h0001, 16'hFFFF, 1'b1, 0);
      wait_idle();

      // top floor: one vector just under it, one just over it, then long vectors
      set_floor('1);
      push_pair(16'h7FFF, 16'h7FFF, 1'b1, 0);
      push_pair(16'h8000, 16'h8000, 1'b1, 0);
      for (i = 0; i < 200; i++) push_pair(16'h8000, 16'h8000, i == 199, 0);
      for (i = 0; i < 100; i++) push_pair(16'h8000, 16'h7FFF, i == 99, 0);
      wait_idle();

      set_floor(cse_pkg::NORM_W'($urandom_range(0, 1000)));
      random_phase(250);
      wait_idle();
      set_floor(cse_pkg::NORM_W'($urandom_range(0, 30'h3FFF_FFFF)));
      random_phase(250);
      wait_idle();
      set_floor(cse_pkg::NORM_W'(11));
      random_phase(250);
      wait_idle();
      set_floor(cse_pkg::NORM_W'($urandom_range(0, 1 << 24)));
      random_phase(250);
      wait_idle();

      if (mismatch_cnt == 0 && score_q.size() == 0) begin
         $display("cosine_similarity_engine_core verification clean");
      end else begin
         $display("cosine_similarity_engine_core verification failed");
      end
      $finish;
   end

endmodule

// ===== cosine_similarity_engine_core.f =====
+incdir+design
design/cse_pkg.sv
design/cse_datapath.sv
design/cse_ctrl.sv
design/cosine_similarity_engine_core.sv
tb/testbench.sv
